// File: rtl/dtth_pkg.sv
`timescale 1ns / 1ps

package dtth_pkg;

  // Action codes of an input word
  localparam logic [1:0] ACT_SET    = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_GET    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_TICK_BITS = 2'd0;
  localparam logic [1:0] CFG_US_SCALE  = 2'd1;
  localparam logic [1:0] CFG_US_SHIFT  = 2'd2;

  // Configuration reset values
  localparam logic [5:0]  TICK_BITS_RST = 6'd16;
  localparam logic [31:0] US_SCALE_RST  = 32'd1;
  localparam logic [5:0]  US_SHIFT_RST  = 6'd0;

  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [31:0] REBASE_SEC   = 32'd4200;

  // x / 1e6 == (x * DIV_MAGIC) >> 50, exact for any 32-bit x
  localparam logic [31:0] DIV_MAGIC = 32'd1125899907;
  localparam int          DIV_SHIFT = 50;
  localparam int          QUOT_W    = 13;  // max quotient 4294

  // Time carried alongside a conversion: base time, or host time on bypass
  typedef struct packed {
    logic        bypass;
    logic [31:0] sec;
    logic [19:0] usec;
  } tref_t;

  // Extended tick count handed to the scaler
  typedef struct packed {
    logic [63:0] ticks;
    tref_t       tref;
  } get_word_t;

  // Scaled microseconds handed to the splitter
  typedef struct packed {
    logic [31:0] du;
    tref_t       tref;
  } us_word_t;

  // Tick difference, masked to the counter width when the tick went backwards
  function automatic logic [31:0] masked_diff(input logic [31:0] now,
                                              input logic [31:0] tick_ref,
                                              input logic [5:0]  bits);
    logic [31:0] d;
    logic [31:0] m;
    d = now - tick_ref;
    if (bits >= 6'd32) begin
      m = '1;
    end else begin
      m = (32'd1 << bits) - 32'd1;
    end
    if (now < tick_ref) begin
      d = d & m;
    end
    return d;
  endfunction

endpackage

// File: rtl/dtth_front.sv
`timescale 1ns / 1ps

module dtth_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [5:0]            tick_bits,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [1:0]            up_action,
  input  logic [31:0]           up_tick,
  input  logic [31:0]           up_hsec,
  input  logic [19:0]           up_husec,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output dtth_pkg::get_word_t   dn_word
);

  // Input register
  logic        va_r;
  logic [1:0]  act_r;
  logic [31:0] tick_r;
  logic [31:0] hsec_r;
  logic [19:0] husec_r;

  // Time base state
  logic [31:0] prev_tick_r, prev_tick_nxt;
  logic [31:0] last_tick_r, last_tick_nxt;
  logic [63:0] total_r, total_nxt;
  logic [31:0] base_sec_r, base_sec_nxt;
  logic [19:0] base_usec_r, base_usec_nxt;
  logic [31:0] lh_sec_r, lh_sec_nxt;
  logic [19:0] lh_usec_r, lh_usec_nxt;

  // Get output register
  logic                vg_r;
  dtth_pkg::get_word_t word_r, word_nxt;

  logic        is_get, is_set, is_upd;
  logic        rd_g, fire;
  logic [31:0] tick_ref, diff;
  logic [63:0] total_keep;
  logic        rebase;

  assign is_get = (act_r == dtth_pkg::ACT_GET);
  assign is_set = (act_r == dtth_pkg::ACT_SET);
  assign is_upd = (act_r == dtth_pkg::ACT_UPDATE);

  // Only a get needs room downstream
  assign rd_g     = !vg_r || dn_ready;
  assign fire     = va_r && (!is_get || rd_g);
  assign up_ready = !va_r || fire;

  assign tick_ref = is_upd ? prev_tick_r : last_tick_r;
  assign diff     = dtth_pkg::masked_diff(tick_r, tick_ref, tick_bits);
  assign rebase   = (lh_sec_r != '0) && ((lh_sec_r - base_sec_r) > dtth_pkg::REBASE_SEC);

  // State update for set and update words
  always_comb begin
    prev_tick_nxt = prev_tick_r;
    last_tick_nxt = last_tick_r;
    total_nxt     = total_r;
    base_sec_nxt  = base_sec_r;
    base_usec_nxt = base_usec_r;
    lh_sec_nxt    = lh_sec_r;
    lh_usec_nxt   = lh_usec_r;
    total_keep    = total_r;
    if (fire && is_set) begin
      if (base_sec_r == '0) begin
        base_sec_nxt  = hsec_r;
        base_usec_nxt = husec_r;
        lh_sec_nxt    = '0;
      end else begin
        if (rebase) begin
          base_sec_nxt  = lh_sec_r;
          base_usec_nxt = lh_usec_r;
          total_keep    = '0;
        end
        lh_sec_nxt  = hsec_r;
        lh_usec_nxt = husec_r;
      end
      prev_tick_nxt = last_tick_r;
      last_tick_nxt = tick_r;
      total_nxt     = total_keep;
      if (lh_sec_nxt != '0) begin
        total_nxt = total_keep + {32'b0, diff};
      end
    end else if (fire && is_upd) begin
      last_tick_nxt = tick_r;
      if (lh_sec_r != '0) begin
        total_nxt = total_r + {32'b0, diff};
      end
    end
  end

  // Get word: extended tick count and time reference
  always_comb begin
    word_nxt.ticks       = {32'b0, diff} + total_r;
    word_nxt.tref.bypass = (lh_sec_r == '0);
    word_nxt.tref.sec    = word_nxt.tref.bypass ? hsec_r  : base_sec_r;
    word_nxt.tref.usec   = word_nxt.tref.bypass ? husec_r : base_usec_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vg_r        <= 1'b0;
      prev_tick_r <= '0;
      last_tick_r <= '0;
      total_r     <= '0;
      base_sec_r  <= '0;
      base_usec_r <= '0;
      lh_sec_r    <= '0;
      lh_usec_r   <= '0;
    end else begin
      if (up_ready) begin
        va_r <= up_valid;
      end
      if (rd_g) begin
        vg_r <= fire && is_get;
      end
      prev_tick_r <= prev_tick_nxt;
      last_tick_r <= last_tick_nxt;
      total_r     <= total_nxt;
      base_sec_r  <= base_sec_nxt;
      base_usec_r <= base_usec_nxt;
      lh_sec_r    <= lh_sec_nxt;
      lh_usec_r   <= lh_usec_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      act_r   <= up_action;
      tick_r  <= up_tick;
      hsec_r  <= up_hsec;
      husec_r <= up_husec;
    end
    if (fire && is_get) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = vg_r;
  assign dn_word  = word_r;

endmodule

// File: rtl/dtth_scale.sv
`timescale 1ns / 1ps

module dtth_scale (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [31:0]           us_scale,
  input  logic [5:0]            us_shift,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  dtth_pkg::get_word_t   up_word,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output dtth_pkg::us_word_t    dn_word
);

  // Stage B: low partial product
  logic                vb_r;
  logic [63:0]         lo_r;
  logic [31:0]         hi_r;
  dtth_pkg::tref_t     tref_b_r;
  // Stage C: full product modulo 2^64
  logic                vc_r;
  logic [63:0]         prod_r;
  dtth_pkg::tref_t     tref_c_r;
  // Stage D: shifted microseconds
  logic                vd_r;
  dtth_pkg::us_word_t  word_r;

  logic        rd_b, rd_c, rd_d;
  logic [63:0] lo_nxt, hp, prod_nxt, sh;

  assign rd_d     = !vd_r || dn_ready;
  assign rd_c     = !vc_r || rd_d;
  assign rd_b     = !vb_r || rd_c;
  assign up_ready = rd_b;

  assign lo_nxt   = {32'b0, up_word.ticks[31:0]} * {32'b0, us_scale};
  // Only the low half of the high partial product lands below bit 64
  assign hp       = {32'b0, hi_r} * {32'b0, us_scale};
  assign prod_nxt = {lo_r[63:32] + hp[31:0], lo_r[31:0]};
  assign sh       = prod_r >> us_shift;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (rd_b) vb_r <= up_valid;
      if (rd_c) vc_r <= vb_r;
      if (rd_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_b && up_valid) begin
      lo_r     <= lo_nxt;
      hi_r     <= up_word.ticks[63:32];
      tref_b_r <= up_word.tref;
    end
    if (rd_c && vb_r) begin
      prod_r   <= prod_nxt;
      tref_c_r <= tref_b_r;
    end
    if (rd_d && vc_r) begin
      word_r.du   <= sh[31:0];
      word_r.tref <= tref_c_r;
    end
  end

  assign dn_valid = vd_r;
  assign dn_word  = word_r;

endmodule

// File: rtl/dtth_split.sv
`timescale 1ns / 1ps

module dtth_split (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  dtth_pkg::us_word_t    up_word,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic [31:0]           dn_sec,
  output logic [19:0]           dn_usec
);

  localparam int QW = dtth_pkg::QUOT_W;

  // Stage E: seconds quotient
  logic                vE_r;
  logic [QW-1:0]       q_e_r;
  logic [31:0]         du_e_r;
  dtth_pkg::tref_t     tref_e_r;
  // Stage F: microsecond remainder
  logic                vf_r;
  logic [QW-1:0]       q_f_r;
  logic [19:0]         rem_r;
  dtth_pkg::tref_t     tref_f_r;
  // Stage G: output register
  logic                out_valid_r;
  logic [31:0]         sec_r, sec_nxt;
  logic [19:0]         usec_r, usec_nxt;

  logic        rd_e, rd_f, rd_g;
  logic [63:0] qp;
  logic [32:0] qm, rem_full;
  logic [20:0] usum, ufix;
  logic        carry;

  assign rd_g     = !out_valid_r || dn_ready;
  assign rd_f     = !vf_r || rd_g;
  assign rd_e     = !vE_r || rd_f;
  assign up_ready = rd_e;

  // Divide by one million through the reciprocal
  assign qp       = {32'b0, up_word.du} * {32'b0, dtth_pkg::DIV_MAGIC};
  assign qm       = {{(33-QW){1'b0}}, q_e_r} * {13'b0, dtth_pkg::USEC_PER_SEC};
  assign rem_full = {1'b0, du_e_r} - qm;

  // Add to base time, one carry step into seconds; host time passes through on bypass
  always_comb begin
    usum  = {1'b0, tref_f_r.usec} + {1'b0, rem_r};
    carry = (usum >= {1'b0, dtth_pkg::USEC_PER_SEC});
    ufix  = carry ? (usum - {1'b0, dtth_pkg::USEC_PER_SEC}) : usum;
    if (tref_f_r.bypass) begin
      sec_nxt  = tref_f_r.sec;
      usec_nxt = tref_f_r.usec;
    end else begin
      sec_nxt  = tref_f_r.sec + {{(32-QW){1'b0}}, q_f_r} + {31'b0, carry};
      usec_nxt = ufix[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vE_r        <= 1'b0;
      vf_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rd_e) vE_r        <= up_valid;
      if (rd_f) vf_r        <= vE_r;
      if (rd_g) out_valid_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_e && up_valid) begin
      q_e_r    <= qp[dtth_pkg::DIV_SHIFT+QW-1:dtth_pkg::DIV_SHIFT];
      du_e_r   <= up_word.du;
      tref_e_r <= up_word.tref;
    end
    if (rd_f && vE_r) begin
      q_f_r    <= q_e_r;
      rem_r    <= rem_full[19:0];
      tref_f_r <= tref_e_r;
    end
    if (rd_g && vf_r) begin
      sec_r  <= sec_nxt;
      usec_r <= usec_nxt;
    end
  end

  assign dn_valid = out_valid_r;
  assign dn_sec   = sec_r;
  assign dn_usec  = usec_r;

`ifndef SYNTH
  // Remainder is always a proper microsecond count
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    vf_r |-> (rem_r < dtth_pkg::USEC_PER_SEC))
    else $error("remainder out of range");

  // Quotient of a 32-bit value by one million stays below 4295
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    vE_r |-> (q_e_r <= 13'd4294))
    else $error("quotient out of range");

  // Quotient and remainder rebuild the scaled value
  a_div_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_f && vE_r) |=> ({13'b0, rem_r} +
      ({{(33-QW){1'b0}}, q_f_r} * {13'b0, dtth_pkg::USEC_PER_SEC})) == $past(du_e_r))
    else $error("division mismatch");

  // A finished conversion moves into the output register when room is there
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (vf_r && rd_g) |=> out_valid_r)
    else $error("result lost");
`endif

endmodule

// File: rtl/device_timestamp_to_host_time_unit.sv
`timescale 1ns / 1ps

// A get word passes the front's input and get registers, then stages B to G.
// Throughput: one word per cycle unless out_ready stalls; set and update
// words give no result. The state update loop of the front stage sets the
// rate. Reset: synchronous, active-low rst_n clears the time base state to
// zero and loads the configuration defaults; no clearing pass.
module device_timestamp_to_host_time_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_dev_tick,
  input  logic [31:0] in_host_sec,
  input  logic [19:0] in_host_usec,
  // Result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sec,
  output logic [19:0] out_usec
);

  logic [5:0]  tick_bits_r;
  logic [31:0] us_scale_r;
  logic [5:0]  us_shift_r;

  logic                g_valid, g_ready;
  dtth_pkg::get_word_t g_word;
  logic                u_valid, u_ready;
  dtth_pkg::us_word_t  u_word;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_bits_r <= dtth_pkg::TICK_BITS_RST;
      us_scale_r  <= dtth_pkg::US_SCALE_RST;
      us_shift_r  <= dtth_pkg::US_SHIFT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dtth_pkg::CFG_TICK_BITS: tick_bits_r <= cfg_data[5:0];
        dtth_pkg::CFG_US_SCALE:  us_scale_r  <= cfg_data;
        dtth_pkg::CFG_US_SHIFT:  us_shift_r  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  dtth_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_bits (tick_bits_r),
    .up_valid  (in_valid),
    .up_ready  (in_ready),
    .up_action (in_action),
    .up_tick   (in_dev_tick),
    .up_hsec   (in_host_sec),
    .up_husec  (in_host_usec),
    .dn_valid  (g_valid),
    .dn_ready  (g_ready),
    .dn_word   (g_word)
  );

  dtth_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .us_scale (us_scale_r),
    .us_shift (us_shift_r),
    .up_valid (g_valid),
    .up_ready (g_ready),
    .up_word  (g_word),
    .dn_valid (u_valid),
    .dn_ready (u_ready),
    .dn_word  (u_word)
  );

  dtth_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (u_valid),
    .up_ready (u_ready),
    .up_word  (u_word),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_sec   (out_sec),
    .dn_usec  (out_usec)
  );

endmodule
